/* rtl/amh_pkg.sv */
// amh_pkg: shared widths, command codes and the range scale table for the
// acceleration magnitude history block. No dependencies.
`default_nettype none

package amh_pkg;

  // history depth (entries kept, newest first)
  localparam int HISTORY_DEPTH = 16;
  localparam int HIST_IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // field widths
  localparam int AXIS_W  = 16;
  localparam int TIME_W  = 32;
  localparam int INDEX_W = 4;
  localparam int MAG_W   = 25;
  localparam int RANGE_W = 2;

  // datapath widths
  localparam int SUM_W      = 2 * AXIS_W;     // x^2 + y^2 + z^2 fits 32 bits
  localparam int FRAC_BITS  = 8;              // root fraction bits
  localparam int RAD_W      = SUM_W + 2 * FRAC_BITS;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SCALE_W    = 9;
  localparam int MUL_A_W    = ROOT_W;
  localparam int MUL_B_W    = AXIS_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // range step in units of 0.0001 g, indexed by range_code
  localparam logic [SCALE_W-1:0] RANGE_SCALE [4] = '{
    9'd39, 9'd78, 9'd156, 9'd312
  };

endpackage

`default_nettype wire

/* rtl/accel_magnitude_history_core.sv */
// accel_magnitude_history_core: top level, sequencer around one shared
// multiplier and the iterative square root. Uses amh_pkg, amh_isqrt, amh_history.
`default_nettype none

// usage
//   input channel: in_valid / in_stall with cmd, accel_x/y/z, sample_time and
//   history_index. a request is taken when in_valid is high and in_stall low.
//   cmd sample computes sqrt(x^2+y^2+z^2) with 8 fraction bits, scales it by
//   the range step (0.0001 g units) and pushes magnitude and time into the
//   newest-first history; cmd read returns the entry at history_index.
//   output channel: out_valid / out_stall with magnitude and magnitude_time,
//   one result per request, held steady while out_stall is high.
//   config channel: cfg_valid / cfg_ready with cfg_data = range_code; always
//   ready, write only while the block is idle.
//   timing: a sample reaches the output register through these steps, in
//   order: the three squares and their sum, a state to start the root,
//   the 24 one-bit root steps, one to see the root done, one multiplier pass
//   for the range step, one to drop the fraction and one to load the result.
//   a read goes straight to the load. in_stall drops the cycle after the load,
//   so a new request is taken only once the last result is loaded. a stalled
//   result holds the next request at the output register with in_stall high.
//   reset: synchronous, clears the history to zeros, range_code to 0 and
//   empties the output register.

module accel_magnitude_history_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [amh_pkg::RANGE_W-1:0]       cfg_data,
  // request channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              cmd,
  input  wire logic signed [amh_pkg::AXIS_W-1:0] accel_x,
  input  wire logic signed [amh_pkg::AXIS_W-1:0] accel_y,
  input  wire logic signed [amh_pkg::AXIS_W-1:0] accel_z,
  input  wire logic [amh_pkg::TIME_W-1:0]        sample_time,
  input  wire logic [amh_pkg::INDEX_W-1:0]       history_index,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [amh_pkg::MAG_W-1:0]              magnitude,
  output logic [amh_pkg::TIME_W-1:0]             magnitude_time
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ROOT_START,
    S_ROOT_WAIT,
    S_SCALE,
    S_RESULT,
    S_DONE
  } state_t;

  state_t state;

  logic [amh_pkg::RANGE_W-1:0]  range_code;
  logic                         cmd_q;
  logic [amh_pkg::AXIS_W-1:0]   ax, ay, az;
  logic [amh_pkg::TIME_W-1:0]   time_q;
  logic [1:0]                   axis_cnt;
  logic [amh_pkg::SUM_W-1:0]    acc;
  logic [amh_pkg::PROD_W-1:0]   prod_q;
  logic [amh_pkg::MAG_W-1:0]    res_mag;
  logic [amh_pkg::TIME_W-1:0]   res_time;

  logic                         in_take;
  logic                         out_free;
  logic                         hist_shift;
  logic [amh_pkg::MUL_A_W-1:0]  mul_a;
  logic [amh_pkg::MUL_B_W-1:0]  mul_b;
  logic [amh_pkg::PROD_W-1:0]   mul_p;

  logic                         sq_start;
  logic                         sq_busy;
  logic                         sq_done;
  logic [amh_pkg::ROOT_W-1:0]   sq_root;
  logic [amh_pkg::MAG_W-1:0]    rd_mag;
  logic [amh_pkg::TIME_W-1:0]   rd_time;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state != S_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign hist_shift = (state == S_DONE) && out_free && (cmd_q == amh_pkg::CMD_SAMPLE);
  assign sq_start   = (state == S_ROOT_START);

  // shared multiplier: squares of the axes, then root times range step
  always_comb begin
    mul_a = amh_pkg::MUL_A_W'(ax);
    mul_b = ax;
    if (state == S_SCALE) begin
      mul_a = sq_root;
      mul_b = amh_pkg::MUL_B_W'(amh_pkg::RANGE_SCALE[range_code]);
    end else begin
      case (axis_cnt)
        2'd0: begin
          mul_a = amh_pkg::MUL_A_W'(ax);
          mul_b = ax;
        end
        2'd1: begin
          mul_a = amh_pkg::MUL_A_W'(ay);
          mul_b = ay;
        end
        2'd2: begin
          mul_a = amh_pkg::MUL_A_W'(az);
          mul_b = az;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
    mul_p = amh_pkg::PROD_W'(mul_a) * amh_pkg::PROD_W'(mul_b);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      range_code <= '0;
    end else if (cfg_valid && cfg_ready) begin
      range_code <= cfg_data;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      axis_cnt  <= '0;
    end else begin
      // in S_DONE the output register is refilled below
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            axis_cnt <= '0;
            state    <= (cmd == amh_pkg::CMD_READ) ? S_DONE : S_SQUARE;
          end
        end
        // product of one axis per cycle, summed in the following cycle
        S_SQUARE: begin
          axis_cnt <= axis_cnt + 2'd1;
          if (axis_cnt == 2'd3) begin
            state <= S_ROOT_START;
          end
        end
        S_ROOT_START: begin
          state <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (sq_done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q    <= cmd;
      ax       <= accel_x[amh_pkg::AXIS_W-1] ? (~accel_x + 1'b1) : accel_x;
      ay       <= accel_y[amh_pkg::AXIS_W-1] ? (~accel_y + 1'b1) : accel_y;
      az       <= accel_z[amh_pkg::AXIS_W-1] ? (~accel_z + 1'b1) : accel_z;
      time_q   <= sample_time;
      res_mag  <= rd_mag;
      res_time <= rd_time;
    end
    if (state == S_SQUARE) begin
      prod_q <= mul_p;
      acc    <= (axis_cnt == 2'd0) ? '0 : acc + prod_q[amh_pkg::SUM_W-1:0];
    end
    if (state == S_SCALE) begin
      prod_q <= mul_p;
    end
    // drop the root's fraction after scaling
    if (state == S_RESULT) begin
      res_mag  <= prod_q[amh_pkg::MAG_W+amh_pkg::FRAC_BITS-1:amh_pkg::FRAC_BITS];
      res_time <= time_q;
    end
    if (state == S_DONE && out_free) begin
      magnitude      <= res_mag;
      magnitude_time <= res_time;
    end
  end

  amh_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ({acc, {(2 * amh_pkg::FRAC_BITS){1'b0}}}),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  amh_history u_history (
    .clk        (clk),
    .rst        (rst),
    .shift_en   (hist_shift),
    .shift_mag  (res_mag),
    .shift_time (res_time),
    .rd_index   (history_index),
    .rd_mag     (rd_mag),
    .rd_time    (rd_time)
  );

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall) else $error("request taken but block not busy");
  a_root_only_waiting: assert property (@(posedge clk) disable iff (rst)
    sq_busy |-> (state == S_ROOT_WAIT)) else $error("root running outside wait");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(magnitude) && $stable(magnitude_time))
    else $error("result changed while stalled");

endmodule

`default_nettype wire

/* rtl/amh_isqrt.sv */
// amh_isqrt: iterative integer square root, one root bit per cycle.
// Depends on amh_pkg for widths.
`default_nettype none

module amh_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [amh_pkg::RAD_W-1:0]     radicand,
  output logic                               busy,
  output logic                               done,
  output logic      [amh_pkg::ROOT_W-1:0]    root
);

  localparam int CNT_W = $clog2(amh_pkg::ROOT_W + 1);

  logic [amh_pkg::RAD_W-1:0]  rad;
  logic [amh_pkg::REM_W-1:0]  rem;
  logic [CNT_W-1:0]           cnt;

  logic [amh_pkg::REM_W-1:0]  rem_sh;
  logic [amh_pkg::REM_W-1:0]  trial;
  logic                       fits;

  // bring down the next two radicand bits and try root*4+1
  always_comb begin
    rem_sh = {rem[amh_pkg::REM_W-3:0], rad[amh_pkg::RAD_W-1 -: 2]};
    trial  = {root, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(amh_pkg::ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[amh_pkg::RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[amh_pkg::ROOT_W-2:0], fits};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy) else $error("isqrt started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("isqrt done longer than one cycle");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("isqrt done without work");

endmodule

`default_nettype wire

/* rtl/amh_history.sv */
// amh_history: newest-first shift history of magnitude and timestamp with
// per-entry valid bits so unwritten entries read as zero. Uses amh_pkg.
`default_nettype none

module amh_history (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           shift_en,
  input  wire logic [amh_pkg::MAG_W-1:0]      shift_mag,
  input  wire logic [amh_pkg::TIME_W-1:0]     shift_time,
  input  wire logic [amh_pkg::INDEX_W-1:0]    rd_index,
  output logic      [amh_pkg::MAG_W-1:0]      rd_mag,
  output logic      [amh_pkg::TIME_W-1:0]     rd_time
);

  logic [amh_pkg::MAG_W-1:0]      mag_mem  [amh_pkg::HISTORY_DEPTH];
  logic [amh_pkg::TIME_W-1:0]     time_mem [amh_pkg::HISTORY_DEPTH];
  logic [amh_pkg::HISTORY_DEPTH-1:0] valid;

  logic [31:0]                       idx_ext;
  logic [amh_pkg::HIST_IDX_W-1:0]    idx;
  logic                              hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (shift_en) begin
      valid[0] <= 1'b1;
      for (int i = 1; i < amh_pkg::HISTORY_DEPTH; i++) begin
        valid[i] <= valid[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      mag_mem[0]  <= shift_mag;
      time_mem[0] <= shift_time;
      for (int i = 1; i < amh_pkg::HISTORY_DEPTH; i++) begin
        mag_mem[i]  <= mag_mem[i-1];
        time_mem[i] <= time_mem[i-1];
      end
    end
  end

  // out of range or never written reads as zero
  always_comb begin
    idx_ext = 32'(rd_index);
    idx     = idx_ext[amh_pkg::HIST_IDX_W-1:0];
    hit     = (idx_ext < 32'(amh_pkg::HISTORY_DEPTH)) && valid[idx];
    rd_mag  = hit ? mag_mem[idx]  : '0;
    rd_time = hit ? time_mem[idx] : '0;
  end

endmodule

`default_nettype wire

/* verif/tb_accel_magnitude_history_core.sv */
// tb_accel_magnitude_history_core: self-checking bench for the acceleration
// magnitude history core, with a directed table followed by random phases.
// Depends on amh_pkg and accel_magnitude_history_core from the rtl folder.
`timescale 1ns / 100ps

module tb_accel_magnitude_history_core;

  // sender / receiver pacing per phase
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // a directed row is either a range write or one request
  typedef enum logic {
    ROW_RANGE,
    ROW_REQUEST
  } row_kind_t;

  typedef struct {
    row_kind_t                           kind;
    logic [amh_pkg::RANGE_W-1:0]         range_val;
    logic                                op;
    logic signed [amh_pkg::AXIS_W-1:0]   ax;
    logic signed [amh_pkg::AXIS_W-1:0]   ay;
    logic signed [amh_pkg::AXIS_W-1:0]   az;
    logic [amh_pkg::TIME_W-1:0]          stamp;
    logic [amh_pkg::INDEX_W-1:0]         idx;
    logic                                typed;      // expected result written in the row
    logic [amh_pkg::MAG_W-1:0]           exp_mag;
    logic [amh_pkg::TIME_W-1:0]          exp_stamp;
  } stim_row_t;

  typedef struct {
    logic [amh_pkg::MAG_W-1:0]  mag;
    logic [amh_pkg::TIME_W-1:0] stamp;
  } mag_result_t;

  localparam int NUM_ROWS   = 23;
  localparam int NUM_PHASES = 5;
  localparam int HOLD_CYCLES = 400;

  logic                              clk;
  logic                              rst;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [amh_pkg::RANGE_W-1:0]       cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic                              cmd;
  logic signed [amh_pkg::AXIS_W-1:0] accel_x;
  logic signed [amh_pkg::AXIS_W-1:0] accel_y;
  logic signed [amh_pkg::AXIS_W-1:0] accel_z;
  logic [amh_pkg::TIME_W-1:0]        sample_time;
  logic [amh_pkg::INDEX_W-1:0]       history_index;
  logic                              out_valid;
  logic                              out_stall;
  logic [amh_pkg::MAG_W-1:0]         magnitude;
  logic [amh_pkg::TIME_W-1:0]        magnitude_time;

  // predictor state: range setting and the newest-first history
  logic [amh_pkg::RANGE_W-1:0] range_now;
  logic [amh_pkg::MAG_W-1:0]   mag_hist   [amh_pkg::HISTORY_DEPTH];
  logic [amh_pkg::TIME_W-1:0]  stamp_hist [amh_pkg::HISTORY_DEPTH];

  // results still owed by the block, oldest first
  mag_result_t pending_results[$];

  idle_mode_t idle_mode;
  int         error_count;

  // long receiver hold-off: the main sequence bumps the request count,
  // the receiver process counts the hold down on its own
  int hold_requests;
  int hold_served;
  int hold_left;

  accel_magnitude_history_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .cmd            (cmd),
    .accel_x        (accel_x),
    .accel_y        (accel_y),
    .accel_z        (accel_z),
    .sample_time    (sample_time),
    .history_index  (history_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .magnitude      (magnitude),
    .magnitude_time (magnitude_time)
  );

  // directed table: reads of the cleared history, axis extremes at every
  // range, exact roots where the magnitude is obvious, and history reads
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_READ,   16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd0,  1'b1, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_READ,   16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd15, 1'b1, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_SAMPLE, 16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd0,  1'b1, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_SAMPLE, 16'sd32767,  16'sd0,      16'sd0,
      32'hFFFF_FFFF, 4'd0, 1'b1, 25'd1277913,  32'hFFFF_FFFF},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_SAMPLE, -16'sd32768, -16'sd32768, -16'sd32768,
      32'h00BC_614E, 4'd0, 1'b0, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_SAMPLE, 16'sd1,      -16'sd1,     16'sd1,
      32'h8000_0000, 4'd0, 1'b0, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_READ,   16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd0,  1'b0, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_READ,   16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd3,  1'b0, 25'd0,        32'h0},
    '{ROW_RANGE,   2'd3, amh_pkg::CMD_SAMPLE, 16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd0,  1'b0, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_SAMPLE, -16'sd32768, -16'sd32768, -16'sd32768,
      32'h0000_0001, 4'd0, 1'b0, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_SAMPLE, 16'sd0,      -16'sd32768, 16'sd0,
      32'h5555_AAAA, 4'd0, 1'b1, 25'd10223616, 32'h5555_AAAA},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_READ,   16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd1,  1'b0, 25'd0,        32'h0},
    '{ROW_RANGE,   2'd1, amh_pkg::CMD_SAMPLE, 16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd0,  1'b0, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_SAMPLE, 16'sd32767,  16'sd32767,  16'sd32767,
      32'hAAAA_5555, 4'd0, 1'b0, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_SAMPLE, 16'sd3,      16'sd4,      16'sd0,
      32'h0000_1000, 4'd0, 1'b1, 25'd390,      32'h0000_1000},
    '{ROW_RANGE,   2'd2, amh_pkg::CMD_SAMPLE, 16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd0,  1'b0, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_SAMPLE, -16'sd1,     16'sd0,      16'sd0,
      32'h0000_2000, 4'd0, 1'b1, 25'd156,      32'h0000_2000},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_SAMPLE, 16'sd0,      16'sd0,      -16'sd32768,
      32'h0000_3000, 4'd0, 1'b1, 25'd5111808,  32'h0000_3000},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_READ,   16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd0,  1'b0, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_READ,   16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd2,  1'b0, 25'd0,        32'h0},
    '{ROW_RANGE,   2'd0, amh_pkg::CMD_SAMPLE, 16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd0,  1'b0, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_SAMPLE, 16'sd12,     -16'sd7,     16'sd100,
      32'h1234_5678, 4'd0, 1'b0, 25'd0,        32'h0},
    '{ROW_REQUEST, 2'd0, amh_pkg::CMD_READ,   16'sd0,      16'sd0,      16'sd0,
      32'h0,        4'd15, 1'b0, 25'd0,        32'h0}
  };

  // random phases: range, pacing, length; the hold-off lands in phase 4
  logic [amh_pkg::RANGE_W-1:0] phase_range [NUM_PHASES] =
    '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3};
  idle_mode_t                  phase_mode  [NUM_PHASES] =
    '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};
  int                          phase_items [NUM_PHASES] = '{200, 200, 200, 250, 250};

  // clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous ceiling on the whole run
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // range step in units of 0.0001 g
  function automatic int unsigned range_step(input logic [amh_pkg::RANGE_W-1:0] rc);
    case (rc)
      2'd0:    return 39;
      2'd1:    return 78;
      2'd2:    return 156;
      default: return 312;
    endcase
  endfunction

  // sqrt(x^2+y^2+z^2) with 8 fraction bits, scaled, fraction dropped
  function automatic logic [amh_pkg::MAG_W-1:0] scaled_magnitude(
    input logic signed [amh_pkg::AXIS_W-1:0] x,
    input logic signed [amh_pkg::AXIS_W-1:0] y,
    input logic signed [amh_pkg::AXIS_W-1:0] z,
    input logic [amh_pkg::RANGE_W-1:0]       rc
  );
    longint     sx;
    longint     sy;
    longint     sz;
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    logic [63:0] scaled;
    sx = x;
    sy = y;
    sz = z;
    if (sx < 0) sx = -sx;
    if (sy < 0) sy = -sy;
    if (sz < 0) sz = -sz;
    rem   = 64'(sx * sx + sy * sy + sz * sz) << 16;
    root  = 64'd0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    // digit-by-digit root, two radicand bits per step
    while (probe != 64'd0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    scaled = (root * 64'(range_step(rc))) >> 8;
    return scaled[amh_pkg::MAG_W-1:0];
  endfunction

  // apply one accepted request to the history and return what it yields
  function automatic mag_result_t predict_result(
    input logic                              op,
    input logic signed [amh_pkg::AXIS_W-1:0] x,
    input logic signed [amh_pkg::AXIS_W-1:0] y,
    input logic signed [amh_pkg::AXIS_W-1:0] z,
    input logic [amh_pkg::TIME_W-1:0]        stamp,
    input logic [amh_pkg::INDEX_W-1:0]       idx
  );
    mag_result_t r;
    if (op == amh_pkg::CMD_SAMPLE) begin
      r.mag   = scaled_magnitude(x, y, z, range_now);
      r.stamp = stamp;
      // shift in at the newest end, the deepest entry falls off
      for (int i = amh_pkg::HISTORY_DEPTH - 1; i > 0; i--) begin
        mag_hist[i]   = mag_hist[i-1];
        stamp_hist[i] = stamp_hist[i-1];
      end
      mag_hist[0]   = r.mag;
      stamp_hist[0] = r.stamp;
    end else if (int'(idx) < amh_pkg::HISTORY_DEPTH) begin
      r.mag   = mag_hist[idx];
      r.stamp = stamp_hist[idx];
    end else begin
      r.mag   = '0;
      r.stamp = '0;
    end
    return r;
  endfunction

  // register write, only once every owed result has come back
  task automatic write_range(input logic [amh_pkg::RANGE_W-1:0] value);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    range_now = value;
    cfg_valid <= 1'b0;
  endtask

  // offer one request, hold it until taken, then record what it owes;
  // a typed expectation replaces the predicted one in the store
  task automatic send_request(
    input logic                              op,
    input logic signed [amh_pkg::AXIS_W-1:0] x,
    input logic signed [amh_pkg::AXIS_W-1:0] y,
    input logic signed [amh_pkg::AXIS_W-1:0] z,
    input logic [amh_pkg::TIME_W-1:0]        stamp,
    input logic [amh_pkg::INDEX_W-1:0]       idx,
    input logic                              typed,
    input mag_result_t                       typed_result
  );
    int          gap;
    int          pct;
    mag_result_t predicted;
    gap = 0;
    pct = (idle_mode == IDLE_BOTH) ? 28 : 83;
    if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
      while ($urandom_range(0, 99) < pct && gap < 60) gap++;
    end
    // idle gap first, so valid is never lowered and raised in one step
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= op;
    accel_x       <= x;
    accel_y       <= y;
    accel_z       <= z;
    sample_time   <= stamp;
    history_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_result(op, x, y, z, stamp, idx);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // random axis value, weighted toward the extremes and small values
  function automatic logic signed [amh_pkg::AXIS_W-1:0] pick_axis();
    case ($urandom_range(0, 9))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'sd0;
      3, 4, 5: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: long hold-off on request, otherwise random stalls by phase
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (idle_mode == IDLE_RECEIVER) begin
      out_stall <= ($urandom_range(0, 99) < 83);
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall <= ($urandom_range(0, 99) < 28);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    mag_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result mag=%0d time=%h",
                                  magnitude, magnitude_time));
      end else begin
        want = pending_results.pop_front();
        if (magnitude !== want.mag)
          report_mismatch($sformatf("magnitude got %0d want %0d",
                                    magnitude, want.mag));
        if (magnitude_time !== want.stamp)
          report_mismatch($sformatf("magnitude_time got %h want %h",
                                    magnitude_time, want.stamp));
      end
    end
  end

  // main sequence
  initial begin
    mag_result_t typed_res;
    logic        op;
    error_count   = 0;
    hold_requests = 0;
    hold_served   = 0;
    hold_left     = 0;
    idle_mode     = IDLE_NONE;
    range_now     = '0;
    for (int i = 0; i < amh_pkg::HISTORY_DEPTH; i++) begin
      mag_hist[i]   = '0;
      stamp_hist[i] = '0;
    end
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    out_stall     = 1'b0;
    cmd           = amh_pkg::CMD_SAMPLE;
    accel_x       = '0;
    accel_y       = '0;
    accel_z       = '0;
    sample_time   = '0;
    history_index = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, range starts at its reset value
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_RANGE) begin
        in_valid <= 1'b0;
        write_range(directed_rows[r].range_val);
      end else begin
        typed_res.mag   = directed_rows[r].exp_mag;
        typed_res.stamp = directed_rows[r].exp_stamp;
        send_request(directed_rows[r].op, directed_rows[r].ax, directed_rows[r].ay,
                     directed_rows[r].az, directed_rows[r].stamp,
                     directed_rows[r].idx, directed_rows[r].typed, typed_res);
      end
    end

    // random phases, each with its own range and pacing
    for (int p = 0; p < NUM_PHASES; p++) begin
      in_valid <= 1'b0;
      write_range(phase_range[p]);
      idle_mode = phase_mode[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        // receiver holds off while the sender keeps offering
        if (p == 4 && n == 30) hold_requests <= hold_requests + 1;
        op = ($urandom_range(0, 9) < 7) ? amh_pkg::CMD_SAMPLE : amh_pkg::CMD_READ;
        send_request(op, pick_axis(), pick_axis(), pick_axis(), $urandom,
                     4'($urandom_range(0, 15)), 1'b0, typed_res);
      end
    end

    in_valid <= 1'b0;
    idle_mode = IDLE_NONE;
    while (pending_results.size() != 0) @(posedge clk);
    // quiet tail: anything that shows up now is flagged by the checker
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
